### hdl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int REQ_W        = 3;
    localparam int STAT_W       = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_DUMP      = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_INVALID = 3'd2,
        STAT_BOUND   = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INS,
        CMD_DEL,
        CMD_ROT
    } cell_op_t;

    // Broadcast to every cell. idx: target slot for insert/delete,
    // wrap slot (last entry) for rotate.
    typedef struct packed {
        cell_op_t                op;
        logic [POS_W-1:0]        idx;
        logic signed [VAL_W-1:0] ins_val;
    } cell_cmd_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_DUMP
    } fsm_t;

endpackage

### hdl/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell
    import ple_pkg::*;
#(
    parameter logic [POS_W-1:0] SLOT = '0
)
(
    input  logic                    clk,
    input  cell_cmd_t               cmd,
    input  logic signed [VAL_W-1:0] left_val,
    input  logic signed [VAL_W-1:0] right_val,
    input  logic signed [VAL_W-1:0] wrap_val,
    output logic signed [VAL_W-1:0] val
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (cmd.op)
            CMD_INS:
            begin
                if (SLOT == cmd.idx)
                begin
                    val_next = cmd.ins_val;
                end
                else if (SLOT > cmd.idx)
                begin
                    val_next = left_val;
                end
            end
            CMD_DEL:
            begin
                if (SLOT >= cmd.idx)
                begin
                    val_next = right_val;
                end
            end
            CMD_ROT:
            begin
                // front value wraps to the last occupied slot
                if (SLOT == cmd.idx)
                begin
                    val_next = wrap_val;
                end
                else
                begin
                    val_next = right_val;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

### hdl/positional_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a row of
// shifting cells, slot 0 being the front. Each request word on the slave side
// (kind in tuser) inserts at the front, back or a 1-based position, deletes
// the front, back or a 1-based position, or dumps the list. Inserts and
// deletes return one word with a status, the removed value (deletes) and the
// new count, always with tlast set. Every cell shifts toward or away from its
// neighbor in the same clock, so such words may follow back to back while
// the master side keeps up. A dump of N entries returns N result words, the
// last with tlast set: the cell row rotates by one slot per word, the front
// slot feeding the output register, and ends back in its original order.
// No new request is taken until the last dump word is in the output
// register. A dump of an empty list gives a single word with status empty.
// Request code 7 is dropped without a result. Cell contents are not reset;
// only slots below the count are ever read.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] item_value, [38:32] position, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_value, [38:32] count, [39] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    cell_cmd_t               cmd;
    logic signed [VAL_W-1:0] vals [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [VAL_W-1:0] left_v;
            logic signed [VAL_W-1:0] right_v;

            if (g == 0)
            begin : g_first
                assign left_v = cmd.ins_val;
            end
            else
            begin : g_mid_l
                assign left_v = vals[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_v = vals[g];
            end
            else
            begin : g_mid_r
                assign right_v = vals[g+1];
            end

            ple_cell #(
                .SLOT (POS_W'(g))
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .left_val  (left_v),
                .right_val (right_v),
                .wrap_val  (vals[0]),
                .val       (vals[g])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    fsm_t               state_reg,     state_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [CNT_W-1:0]   dump_left_reg, dump_left_next;

    logic                    m_valid_reg,  m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic signed [VAL_W-1:0] m_value_reg,  m_value_next;
    logic                    m_last_reg,   m_last_next;
    logic [POS_W-1:0]        m_count_reg,  m_count_next;

    req_t                    in_req;
    logic signed [VAL_W-1:0] in_value;
    logic [POS_W-1:0]        in_pos;
    logic [POS_W-1:0]        count_ext;
    logic                    out_free;
    logic                    in_acc;

    // single-result bookkeeping
    logic                    res_fire;
    status_t                 res_status;
    logic [POS_W-1:0]        rd_idx;
    logic                    rd_use;

    assign in_req    = req_t'(s_tuser[2:0]);
    assign in_value  = s_tdata[31:0];
    assign in_pos    = s_tdata[38:32];
    assign count_ext = POS_W'(count_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == FSM_IDLE) && out_free;
    assign in_acc    = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_left_next = dump_left_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        m_count_next  = m_count_reg;

        cmd.op      = CMD_HOLD;
        cmd.idx     = '0;
        cmd.ins_val = in_value;

        res_fire   = 1'b0;
        res_status = STAT_OK;
        rd_idx     = '0;
        rd_use     = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_req)
                        REQ_INS_FRONT, REQ_INS_BACK:
                        begin
                            res_fire = 1'b1;
                            if (count_ext == CAP_POS)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op     = CMD_INS;
                                cmd.idx    = (in_req == REQ_INS_FRONT) ? '0 : count_ext;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_INS_POS:
                        begin
                            res_fire = 1'b1;
                            if (in_pos == '0)
                            begin
                                res_status = STAT_INVALID;
                            end
                            else if (in_pos > count_ext + POS_W'(1))
                            begin
                                res_status = STAT_BOUND;
                            end
                            else if (count_ext == CAP_POS)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op     = CMD_INS;
                                cmd.idx    = in_pos - POS_W'(1);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DEL_FRONT, REQ_DEL_BACK:
                        begin
                            res_fire = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                rd_use     = 1'b1;
                                rd_idx     = (in_req == REQ_DEL_FRONT) ? '0
                                                                      : count_ext - POS_W'(1);
                                cmd.op     = CMD_DEL;
                                cmd.idx    = rd_idx;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_DEL_POS:
                        begin
                            res_fire = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else if (in_pos == '0)
                            begin
                                res_status = STAT_INVALID;
                            end
                            else if (in_pos > count_ext)
                            begin
                                res_status = STAT_BOUND;
                            end
                            else
                            begin
                                rd_use     = 1'b1;
                                rd_idx     = in_pos - POS_W'(1);
                                cmd.op     = CMD_DEL;
                                cmd.idx    = rd_idx;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_fire   = 1'b1;
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next     = FSM_DUMP;
                                dump_left_next = count_reg;
                            end
                        end
                        default:
                        begin
                            res_fire = 1'b0;
                        end
                    endcase

                    if (res_fire)
                    begin
                        m_valid_next  = 1'b1;
                        m_status_next = res_status;
                        m_value_next  = rd_use ? vals[rd_idx[IDX_W-1:0]] : '0;
                        m_last_next   = 1'b1;
                        m_count_next  = POS_W'(count_next);
                    end
                end
            end
            FSM_DUMP:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    m_status_next  = STAT_OK;
                    m_value_next   = vals[0];
                    m_last_next    = (dump_left_reg == CNT_W'(1));
                    m_count_next   = count_ext;
                    cmd.op         = CMD_ROT;
                    cmd.idx        = count_ext - POS_W'(1);
                    dump_left_next = dump_left_reg - CNT_W'(1);
                    if (dump_left_reg == CNT_W'(1))
                    begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            dump_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_value_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= CAP_POS)
        else $error("entry count above capacity");

    a_dump_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DUMP) |-> (dump_left_reg != '0) && (dump_left_reg <= count_reg))
        else $error("dump counter out of range");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DUMP) |=> $stable(count_reg))
        else $error("count changed during dump");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DUMP && out_free && dump_left_reg == CNT_W'(1))
            |=> (state_reg == FSM_IDLE) && m_tvalid && m_tlast)
        else $error("dump did not close with last word");

endmodule

### tb/tb_positional_list_engine.sv
`timescale 1ns / 1ps

// Self-checking bench for positional_list_engine.
// A driver block pulls request words from a queue and a monitor block
// checks result words against a shadow list kept inside the bench.
module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int HOLD_LEN    = 250;     // long output stall, in cycles
    localparam int DRAIN_WAIT  = 2 * LIST_CAP + 8;
    localparam int CYCLE_LIMIT = 400000;

    // Unused request code: the block drops it and sends no word back.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef enum int
    {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } mix_t;

    typedef struct
    {
        logic [REQ_W-1:0]        kind;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
    } list_req_t;

    typedef struct
    {
        status_t                 status;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic [POS_W-1:0]        count;
    } list_word_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // [31:0] item_value, [38:32] position, [39] zero
    logic [2:0]  s_tuser  = '0;    // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [31:0] out_value, [38:32] count, [39] zero
    logic [2:0]  m_tuser;          // [2:0] status
    logic        m_tlast;

    positional_list_engine #(
        .CAPACITY (LIST_CAP)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    list_req_t  pending_reqs[$];      // request words not yet offered
    list_req_t  offered_req;          // word currently on the slave side
    list_word_t expected_words[$];    // result words still owed by the block

    // Shadow of the cell row: slot 0 is the front.
    logic signed [VAL_W-1:0] shadow_vals [LIST_CAP];
    int shadow_len = 0;

    // Length seen by the stimulus generator, so positions stay meaningful.
    int plan_len = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_granted   = 0;
    int hold_left      = 0;

    int fail_count    = 0;
    int cycle_count   = 0;
    int accepted_reqs = 0;
    int dump_reqs     = 0;
    int words_checked = 0;
    int peak_len      = 0;
    int status_hits [5];

    // ------------------------------------------------------------------
    // Predictor: updates the shadow list for one accepted request and
    // queues the words it must produce. count is taken after the update.
    // ------------------------------------------------------------------
    task automatic owe_word(input status_t st, input logic signed [VAL_W-1:0] v,
                            input logic lst);
        list_word_t w;
        w.status = st;
        w.value  = v;
        w.last   = lst;
        w.count  = POS_W'(shadow_len);
        expected_words.push_back(w);
    endtask

    task automatic apply_request(input list_req_t r);
        int idx;
        int i;
        logic signed [VAL_W-1:0] removed;
        idx = -1;
        removed = '0;
        case (r.kind)
            REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS:
            begin
                // position is checked before fullness on a positional insert
                if (r.kind == REQ_INS_POS && r.pos == 0)
                    owe_word(STAT_INVALID, '0, 1'b1);
                else if (r.kind == REQ_INS_POS && int'(r.pos) > shadow_len + 1)
                    owe_word(STAT_BOUND, '0, 1'b1);
                else if (shadow_len >= LIST_CAP)
                    owe_word(STAT_FULL, '0, 1'b1);
                else
                begin
                    if (r.kind == REQ_INS_FRONT)
                        idx = 0;
                    else if (r.kind == REQ_INS_BACK)
                        idx = shadow_len;
                    else
                        idx = int'(r.pos) - 1;
                    for (i = shadow_len; i > idx; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[idx] = r.value;
                    shadow_len++;
                    owe_word(STAT_OK, '0, 1'b1);
                end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS:
            begin
                // empty wins over any position check
                if (shadow_len == 0)
                    owe_word(STAT_EMPTY, '0, 1'b1);
                else if (r.kind == REQ_DEL_POS && r.pos == 0)
                    owe_word(STAT_INVALID, '0, 1'b1);
                else if (r.kind == REQ_DEL_POS && int'(r.pos) > shadow_len)
                    owe_word(STAT_BOUND, '0, 1'b1);
                else
                begin
                    if (r.kind == REQ_DEL_FRONT)
                        idx = 0;
                    else if (r.kind == REQ_DEL_BACK)
                        idx = shadow_len - 1;
                    else
                        idx = int'(r.pos) - 1;
                    removed = shadow_vals[idx];
                    for (i = idx; i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                    owe_word(STAT_OK, removed, 1'b1);
                end
            end
            REQ_DUMP:
            begin
                dump_reqs++;
                if (shadow_len == 0)
                    owe_word(STAT_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < shadow_len; i++)
                        owe_word(STAT_OK, shadow_vals[i], (i + 1 == shadow_len));
            end
            default:
            begin
                // dropped, nothing owed
            end
        endcase
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position for the planned length, sometimes 0 or past the end.
    function automatic logic [POS_W-1:0] pick_pos(input bit for_insert);
        int top;
        top = for_insert ? plan_len + 1 : plan_len;
        if (top >= 1 && $urandom_range(99) < 85)
            return POS_W'($urandom_range(top, 1));
        if (top + 1 <= 64 && $urandom_range(1) == 1)
            return POS_W'($urandom_range(64, top + 1));
        return '0;
    endfunction

    // Queue one request and keep the planned length in step.
    task automatic queue_req(input logic [REQ_W-1:0] kind,
                             input logic signed [VAL_W-1:0] v,
                             input logic [POS_W-1:0] p);
        list_req_t r;
        r.kind  = kind;
        r.value = v;
        r.pos   = p;
        pending_reqs.push_back(r);
        case (kind)
            REQ_INS_FRONT, REQ_INS_BACK:
                if (plan_len < LIST_CAP) plan_len++;
            REQ_INS_POS:
                if (p != 0 && int'(p) <= plan_len + 1 && plan_len < LIST_CAP) plan_len++;
            REQ_DEL_FRONT, REQ_DEL_BACK:
                if (plan_len > 0) plan_len--;
            REQ_DEL_POS:
                if (plan_len > 0 && p != 0 && int'(p) <= plan_len) plan_len--;
            default:
            begin
            end
        endcase
    endtask

    // A run of random requests; the mix steers the list toward full or empty.
    task automatic queue_random(input int n_items);
        int done;
        int seg_left;
        int ins_pct;
        int r;
        mix_t mix;
        done = 0;
        seg_left = 0;
        ins_pct = 45;
        while (done < n_items)
        begin
            if (seg_left == 0)
            begin
                mix = mix_t'($urandom_range(2));
                seg_left = $urandom_range(40, 15);
                ins_pct = (mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 20 : 45;
            end
            // occasional unused code, not counted
            if ($urandom_range(49) == 0)
                queue_req(REQ_UNUSED, pick_value(), POS_W'($urandom_range(64)));
            r = $urandom_range(99);
            if (r < 6)
                queue_req(REQ_DUMP, pick_value(), POS_W'($urandom_range(64)));
            else if (r < 6 + ins_pct)
            begin
                case ($urandom_range(2))
                    0: queue_req(REQ_INS_FRONT, pick_value(), POS_W'($urandom_range(64)));
                    1: queue_req(REQ_INS_BACK, pick_value(), POS_W'($urandom_range(64)));
                    default: queue_req(REQ_INS_POS, pick_value(), pick_pos(1'b1));
                endcase
            end
            else
            begin
                case ($urandom_range(2))
                    0: queue_req(REQ_DEL_FRONT, pick_value(), POS_W'($urandom_range(64)));
                    1: queue_req(REQ_DEL_BACK, pick_value(), POS_W'($urandom_range(64)));
                    default: queue_req(REQ_DEL_POS, pick_value(), pick_pos(1'b0));
                endcase
            end
            done++;
            seg_left--;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers request words; a held word stays put until taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(offered_req);
                accepted_reqs++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, offered_req.pos, offered_req.value};
                    s_tuser  <= offered_req.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_granted != hold_asked)
        begin
            hold_granted <= hold_asked;
            hold_left    <= HOLD_LEN;
            m_tready     <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each taken result word against the oldest owed word.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: status %0d value %0d count %0d",
                       m_tuser, $signed(m_tdata[31:0]), m_tdata[38:32]);
                fail_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                words_checked++;
                status_hits[w.status]++;
                if (m_tuser !== w.status)
                begin
                    $error("status: expected %0d, actual %0d", w.status, m_tuser);
                    fail_count++;
                end
                if ($signed(m_tdata[31:0]) !== w.value)
                begin
                    $error("out_value: expected %0d, actual %0d",
                           w.value, $signed(m_tdata[31:0]));
                    fail_count++;
                end
                if (m_tlast !== w.last)
                begin
                    $error("out_last: expected %0d, actual %0d", w.last, m_tlast);
                    fail_count++;
                end
                if (m_tdata[38:32] !== w.count)
                begin
                    $error("count: expected %0d, actual %0d", w.count, m_tdata[38:32]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: directed words, then four phases of random words with varying idling.
    // ------------------------------------------------------------------
    task automatic drain_pending();
        while (pending_reqs.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < 5; i++)
            status_hits[i] = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-list refusals
        queue_req(REQ_DUMP,      32'sd0,  7'd0);
        queue_req(REQ_DEL_FRONT, 32'sd0,  7'd0);
        queue_req(REQ_DEL_BACK,  32'sd0,  7'd0);
        queue_req(REQ_DEL_POS,   32'sd0,  7'd0);    // empty beats invalid position
        queue_req(REQ_DEL_POS,   32'sd0,  7'd64);
        queue_req(REQ_INS_POS,   32'sd5,  7'd0);    // invalid position
        queue_req(REQ_INS_POS,   32'sd5,  7'd2);    // past length plus one
        // single entry: out-of-bound delete must not remove it
        queue_req(REQ_INS_POS,   32'sh7FFF_FFFF, 7'd1);
        queue_req(REQ_DEL_POS,   32'sd0,  7'd2);
        queue_req(REQ_DEL_POS,   32'sd0,  7'd0);
        queue_req(REQ_INS_FRONT, 32'sh8000_0000, 7'd127);
        queue_req(REQ_INS_BACK,  -32'sd1, 7'd0);
        queue_req(REQ_INS_POS,   32'sh5A5A_5A5A, 7'd4);  // insert at the tail
        queue_req(REQ_INS_POS,   32'sd0,  7'd2);
        queue_req(REQ_DUMP,      -32'sd1, 7'd127);
        queue_req(REQ_DEL_POS,   32'sd0,  7'd5);    // delete the tail
        queue_req(REQ_DEL_POS,   32'sd0,  7'd5);    // now out of bound
        queue_req(REQ_DEL_POS,   32'sd0,  7'd2);
        queue_req(REQ_UNUSED,    -32'sd1, 7'd127);
        queue_req(REQ_DEL_BACK,  32'sd0,  7'd0);
        queue_req(REQ_DEL_FRONT, 32'sd0,  7'd0);
        queue_req(REQ_DUMP,      32'sd0,  7'd0);
        queue_req(REQ_DEL_POS,   32'sd0,  7'd1);
        drain_pending();

        // Phase 1: no idling. Long output stall while the list fills up.
        hold_asked <= hold_asked + 1;
        for (i = 0; i < LIST_CAP + 2; i++)
            queue_req(REQ_INS_BACK, pick_value(), POS_W'($urandom_range(64)));
        queue_req(REQ_INS_POS,   pick_value(), 7'd33);   // valid spot but full
        queue_req(REQ_INS_POS,   pick_value(), 7'd34);   // bound before full
        queue_req(REQ_INS_POS,   pick_value(), 7'd0);
        queue_req(REQ_INS_FRONT, pick_value(), 7'd0);
        queue_req(REQ_DUMP,      pick_value(), 7'd0);
        queue_random(90);
        drain_pending();

        // Phase 2: sender idles
        send_idle_pct  <= 62;
        recv_stall_pct <= 0;
        queue_random(115);
        drain_pending();

        // Phase 3: receiver stalls
        send_idle_pct  <= 0;
        recv_stall_pct <= 62;
        queue_random(115);
        drain_pending();

        // Phase 4: both sides
        send_idle_pct  <= 33;
        recv_stall_pct <= 33;
        queue_random(115);
        drain_pending();

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d result words from %0d requests (%0d dumps); peak length %0d of %0d.",
                 words_checked, accepted_reqs, dump_reqs, peak_len, LIST_CAP);
        $display("Statuses: ok %0d, empty %0d, invalid %0d, bound %0d, full %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
tb/tb_positional_list_engine.sv
